/* sv/prefix_expression_evaluator_unit_defines.svh */
// Assertion helpers shared by the evaluator RTL.
`ifndef PREFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define PREFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PEE_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PEE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pee_pkg.sv */
package pee_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 32;
   localparam int LEFT_W      = 6;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_A,
      ST_POP_B,
      ST_EXEC,
      ST_DIV,
      ST_FINAL_POP,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

   function automatic op_type decode_op(input logic [7:0] c);
      op_type op;
      case (c)
         CHAR_PLUS:  op = OP_ADD;
         CHAR_MINUS: op = OP_SUB;
         CHAR_STAR:  op = OP_MUL;
         CHAR_SLASH: op = OP_DIV;
         default:    op = OP_NONE;
      endcase
      return op;
   endfunction

   // Saturate the stack count into the 6-bit leftover field.
   function automatic logic [LEFT_W-1:0] leftover(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return (wide > 32'd63) ? 6'd63 : wide[LEFT_W-1:0];
   endfunction

endpackage

/* sv/pee_stack_ram.sv */
module pee_stack_ram (
   input  logic                        clock,
   input  pee_pkg::ram_req_type        ram_req,
   output logic [pee_pkg::DATA_W-1:0]  rd_data
);

   logic [pee_pkg::DATA_W-1:0] mem [pee_pkg::STACK_DEPTH];
   logic [pee_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pee_divider.sv */
`include "prefix_expression_evaluator_unit_defines.svh"

module pee_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pee_pkg::div_req_type  div_req,
   output pee_pkg::div_rsp_type  div_rsp
);

   localparam int W = pee_pkg::DATA_W;
   localparam logic [$clog2(W)-1:0] LAST_BIT = $clog2(W)'(W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [$clog2(W)-1:0] cnt_ff, cnt_in;
   logic [W-1:0]         rem_ff, rem_in;
   logic [W-1:0]         quo_ff, quo_in;
   logic [W-1:0]         mb_ff, mb_in;
   logic                 neg_ff, neg_in;
   logic [W:0]           trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, mb_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend[W-1] ? (W'(0) - div_req.dividend) : div_req.dividend;
         mb_in   = div_req.divisor[W-1] ? (W'(0) - div_req.divisor) : div_req.divisor;
         neg_in  = div_req.dividend[W-1] ^ div_req.divisor[W-1];
      end else if (busy_ff) begin
         // One quotient bit per cycle, restoring.
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
         end
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_BIT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (W'(0) - quo_ff) : quo_ff;

   `PEE_ASSERT_IMPLIES(a_start_idle, clock, reset, div_req.start, !busy_ff && !done_ff, "divider restarted while busy")
   `PEE_ASSERT_NEXT(a_finish, clock, reset, busy_ff && cnt_ff == LAST_BIT && !div_req.start, done_ff && !busy_ff, "divider missed its finish")
   `PEE_ASSERT_IMPLIES(a_done_alone, clock, reset, done_ff, !busy_ff, "divider done while still running")

endmodule

/* sv/prefix_expression_evaluator_unit.sv */
// Prefix expression evaluator.
// req channel: one character beat per cycle at most, fed from the last
// character of the expression to the first; req_last marks the first one.
// rsp channel: one beat per expression, with the final value, the sticky
// underflow/overflow/divide-by-zero flags and the entries left on the stack.
// Digit and space beats are taken in ST_IDLE; an operator goes on through
// two stack reads (ST_POP_A, ST_POP_B) from the stack RAM, then ST_EXEC.
// Division then waits in ST_DIV for the bit-serial divider's quotient.
// The beat with req_last adds the final pop (ST_FINAL_POP, ST_FINAL).
// The result sits in an output register; the next expression's characters
// are taken while it waits. If rsp_ready stays low, the following
// expression holds in ST_FINAL until the register is free.
// Reset clears the stack count, pending number and flags; the stack RAM
// needs no clearing since entries above the count are never read.
// After each result the stack count, pending number and flags are reset.
`include "prefix_expression_evaluator_unit_defines.svh"

module prefix_expression_evaluator_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_character,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_value,
   output logic                rsp_underflow,
   output logic                rsp_overflow,
   output logic                rsp_divide_by_zero,
   output logic [5:0]          rsp_leftover_count
);

   localparam int CW = pee_pkg::CNT_W;
   localparam int AW = pee_pkg::ADDR_W;
   localparam int DW = pee_pkg::DATA_W;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(pee_pkg::STACK_DEPTH);

   pee_pkg::state_type    state_ff, state_in;
   pee_pkg::op_type       op_ff, op_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DW-1:0]         pending_ff, pending_in;
   logic [DW-1:0]         place_ff, place_in;
   logic                  open_ff, open_in;
   logic                  under_ff, under_in;
   logic                  over_ff, over_in;
   logic                  divz_ff, divz_in;
   logic                  last_ff, last_in;
   logic                  empty_ff, empty_in;
   logic [DW-1:0]         left_ff, left_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]         rsp_value_ff, rsp_value_in;
   logic                  rsp_under_ff, rsp_under_in;
   logic                  rsp_over_ff, rsp_over_in;
   logic                  rsp_divz_ff, rsp_divz_in;
   logic [5:0]            rsp_left_ff, rsp_left_in;

   pee_pkg::ram_req_type  ram_req;
   pee_pkg::div_req_type  div_req;
   pee_pkg::div_rsp_type  div_rsp;
   logic [DW-1:0]         rd_data;

   logic                  push_en;
   logic [DW-1:0]         push_data;
   logic                  pop_en;
   logic [CW-1:0]         cnt_mid;
   logic [DW-1:0]         right;
   logic [3:0]            digit;
   logic                  is_digit;
   logic                  slot_free;

   pee_stack_ram u_stack (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   pee_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pee_pkg::ST_IDLE;
         count_ff     <= '0;
         pending_ff   <= '0;
         place_ff     <= DW'(1);
         open_ff      <= 1'b0;
         under_ff     <= 1'b0;
         over_ff      <= 1'b0;
         divz_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         place_ff     <= place_in;
         open_ff      <= open_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         divz_ff      <= divz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      last_ff      <= last_in;
      empty_ff     <= empty_in;
      left_ff      <= left_in;
      rsp_value_ff <= rsp_value_in;
      rsp_under_ff <= rsp_under_in;
      rsp_over_ff  <= rsp_over_in;
      rsp_divz_ff  <= rsp_divz_in;
      rsp_left_ff  <= rsp_left_in;
   end

   assign is_digit  = (req_character >= pee_pkg::CHAR_ZERO)
                   && (req_character <= pee_pkg::CHAR_NINE);
   assign digit     = 4'(req_character - pee_pkg::CHAR_ZERO);
   assign right     = empty_ff ? '0 : rd_data;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pee_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      place_in     = place_ff;
      open_in      = open_ff;
      under_in     = under_ff;
      over_in      = over_ff;
      divz_in      = divz_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_under_in = rsp_under_ff;
      rsp_over_in  = rsp_over_ff;
      rsp_divz_in  = rsp_divz_ff;
      rsp_left_in  = rsp_left_ff;
      push_en      = 1'b0;
      push_data    = pending_ff;
      pop_en       = 1'b0;
      div_req      = '0;
      div_req.dividend = left_ff;
      div_req.divisor  = right;

      case (state_ff)
         pee_pkg::ST_IDLE: begin
            if (req_valid) begin
               last_in = req_last;
               op_in   = pee_pkg::decode_op(req_character);
               if (is_digit) begin
                  pending_in = pending_ff + DW'(place_ff * DW'(digit));
                  place_in   = (place_ff << 3) + (place_ff << 1);
                  open_in    = 1'b1;
                  if (req_last) begin
                     // Push the finished number ahead of the final pop.
                     push_en   = 1'b1;
                     push_data = pending_in;
                     state_in  = pee_pkg::ST_FINAL_POP;
                  end
               end else begin
                  // Close any open number before the operator or end.
                  push_en    = open_ff;
                  open_in    = 1'b0;
                  pending_in = '0;
                  place_in   = DW'(1);
                  if (req_character != pee_pkg::CHAR_SPACE) begin
                     state_in = pee_pkg::ST_POP_A;
                  end else if (req_last) begin
                     state_in = pee_pkg::ST_FINAL_POP;
                  end
               end
            end
         end
         pee_pkg::ST_POP_A: begin
            pop_en   = 1'b1;
            state_in = pee_pkg::ST_POP_B;
         end
         pee_pkg::ST_POP_B: begin
            left_in  = empty_ff ? '0 : rd_data;
            pop_en   = 1'b1;
            state_in = pee_pkg::ST_EXEC;
         end
         pee_pkg::ST_EXEC: begin
            state_in = last_ff ? pee_pkg::ST_FINAL_POP : pee_pkg::ST_IDLE;
            case (op_ff)
               pee_pkg::OP_ADD: begin
                  push_en   = 1'b1;
                  push_data = left_ff + right;
               end
               pee_pkg::OP_SUB: begin
                  push_en   = 1'b1;
                  push_data = left_ff - right;
               end
               pee_pkg::OP_MUL: begin
                  push_en   = 1'b1;
                  push_data = DW'(left_ff * right);
               end
               pee_pkg::OP_DIV: begin
                  if (right == '0) begin
                     push_en   = 1'b1;
                     push_data = '0;
                     divz_in   = 1'b1;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = pee_pkg::ST_DIV;
                  end
               end
               default: begin
               end
            endcase
         end
         pee_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               push_en   = 1'b1;
               push_data = div_rsp.quotient;
               state_in  = last_ff ? pee_pkg::ST_FINAL_POP : pee_pkg::ST_IDLE;
            end
         end
         pee_pkg::ST_FINAL_POP: begin
            pop_en   = 1'b1;
            state_in = pee_pkg::ST_FINAL;
         end
         pee_pkg::ST_FINAL: begin
            // Hold the popped value until the output register frees up.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = empty_ff ? '0 : rd_data;
               rsp_under_in = under_ff;
               rsp_over_in  = over_ff;
               rsp_divz_in  = divz_ff;
               rsp_left_in  = pee_pkg::leftover(count_ff);
               count_in     = '0;
               pending_in   = '0;
               place_in     = DW'(1);
               open_in      = 1'b0;
               under_in     = 1'b0;
               over_in      = 1'b0;
               divz_in      = 1'b0;
               state_in     = pee_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pee_pkg::ST_IDLE;
         end
      endcase

      // Stack pointer update: at most one push or one pop per cycle.
      cnt_mid = count_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = count_ff[AW-1:0];
      ram_req.wr_data = push_data;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = AW'(count_ff - 1'b1);
      if (push_en) begin
         if (count_ff < DEPTH_CNT) begin
            ram_req.wr_en = 1'b1;
            cnt_mid       = count_ff + 1'b1;
         end else begin
            over_in = 1'b1;
         end
      end
      if (pop_en) begin
         empty_in = (count_ff == '0);
         if (count_ff == '0) begin
            under_in = 1'b1;
         end else begin
            ram_req.rd_en = 1'b1;
            cnt_mid       = count_ff - 1'b1;
         end
      end
      if (push_en || pop_en) begin
         count_in = cnt_mid;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_underflow      = rsp_under_ff;
   assign rsp_overflow       = rsp_over_ff;
   assign rsp_divide_by_zero = rsp_divz_ff;
   assign rsp_leftover_count = rsp_left_ff;

   `PEE_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_CNT, "stack count past depth")
   `PEE_ASSERT_IMPLIES(a_push_room, clock, reset, ram_req.wr_en, count_ff < DEPTH_CNT, "stack write with no room")
   `PEE_ASSERT_IMPLIES(a_div_wait, clock, reset, div_rsp.done, state_ff == pee_pkg::ST_DIV, "quotient arrived outside divide wait")
   `PEE_ASSERT_NEXT(a_rsp_load, clock, reset, state_ff == pee_pkg::ST_FINAL && slot_free, rsp_valid_ff && count_ff == '0 && state_ff == pee_pkg::ST_IDLE, "result not loaded or state not cleared")

endmodule
